@@ hw/rtl/swfd_pkg.sv @@
package swfd_pkg;

	localparam int SIZE_FIELD_BYTES = 2;
	localparam int SEQ_BYTES        = 2;
	localparam int CHECKSUM_BYTES   = 4;
	localparam int MAX_FRAME_BYTES  = 4096;

	localparam int SIZE_ACC_W = 8 * SIZE_FIELD_BYTES;
	localparam int SEQ_ACC_W  = 8 * SEQ_BYTES;
	localparam int CKSUM_W    = 8 * CHECKSUM_BYTES;

	localparam int CFG_W     = 13;
	localparam int IDX_W     = 12;
	localparam int SEQ_OUT_W = 16;
	localparam int CNT_W     = 32;

	localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 13'd1024;

	localparam logic [7:0] SYNC_A = 8'h5A;
	localparam logic [7:0] SYNC_B = 8'hA5;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_SYNC    = 3'd1,
		EV_LOST    = 3'd2,
		EV_SIZE    = 3'd3,
		EV_CKSUM   = 3'd4,
		EV_GOOD    = 3'd5
	} ev_t;

	typedef enum logic {
		OP_BYTE  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	// One classified word handed from the parser to the counter side.
	typedef struct packed {
		logic                 is_clear;
		logic                 payload_valid;
		logic [IDX_W-1:0]     payload_index;
		logic [7:0]           payload_byte;
		ev_t                  ev;
		logic [SEQ_OUT_W-1:0] seq_number;
	} item_t;

endpackage

@@ hw/rtl/sync_word_frame_deframer.sv @@
// Sync-word frame deframer. Received bytes enter one word per cycle on the
// input channel while in_stall is low; each word (or a counter-clear
// command) yields exactly one result word on the output channel, in order.
// The parser hunts for the sync word 5A A5 5A A5, checks the little-endian
// size field against expected_frame_size, then passes the sequence and data
// bytes out as payload while summing them, and compares the sum against the
// trailing 32-bit checksum. Events (sync, lost sync, size error, checksum
// error, good frame) and six wrapping 32-bit counters ride along with every
// result. Rate: one word per clock while in_stall is low; each result word
// is written into the queue, then registered in the output stage, where it
// is held while the output is stalled. The parser feeds a two-entry queue,
// and in_stall is simply that queue's full flag, so the input keeps flowing
// while one finished result waits on a stalled output. Write
// expected_frame_size only while no words are in flight.
module sync_word_frame_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [swfd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           payload_valid,
	output logic [swfd_pkg::IDX_W-1:0]     payload_index,
	output logic [7:0]                     payload_byte,
	output logic [2:0]                     event_res,
	output logic [swfd_pkg::SEQ_OUT_W-1:0] seq_number,
	output logic [swfd_pkg::CNT_W-1:0]     byte_count,
	output logic [swfd_pkg::CNT_W-1:0]     good_frame_count,
	output logic [swfd_pkg::CNT_W-1:0]     sync_count,
	output logic [swfd_pkg::CNT_W-1:0]     lost_sync_count,
	output logic [swfd_pkg::CNT_W-1:0]     size_error_count,
	output logic [swfd_pkg::CNT_W-1:0]     checksum_error_count
);
	import swfd_pkg::*;

	logic [CFG_W-1:0] frame_size_q;
	logic             q_full, q_empty, q_push, q_pop;
	item_t            push_item, pop_item;

	// The register write is always taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q <= FRAME_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frame_size_q <= cfg_data;
		end
	end

	// Front: parse and classify each word, push one item per accepted word.
	swfd_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.expected_frame_size (frame_size_q),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.op                  (op),
		.rx_byte             (rx_byte),
		.q_full              (q_full),
		.q_push              (q_push),
		.q_item              (push_item)
	);

	// Decouple parser from the output handshake.
	swfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	// Back: advance counters, hold the result until it is taken.
	swfd_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.q_empty              (q_empty),
		.q_item               (pop_item),
		.q_pop                (q_pop),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.payload_valid        (payload_valid),
		.payload_index        (payload_index),
		.payload_byte         (payload_byte),
		.event_res            (event_res),
		.seq_number           (seq_number),
		.byte_count           (byte_count),
		.good_frame_count     (good_frame_count),
		.sync_count           (sync_count),
		.lost_sync_count      (lost_sync_count),
		.size_error_count     (size_error_count),
		.checksum_error_count (checksum_error_count)
	);

endmodule

@@ hw/rtl/swfd_front.sv @@
module swfd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [swfd_pkg::CFG_W-1:0] expected_frame_size,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [7:0]                 rx_byte,
	input  logic                       q_full,
	output logic                       q_push,
	output swfd_pkg::item_t            q_item
);
	import swfd_pkg::*;

	typedef enum logic [3:0] {
		PS_LOST  = 4'd0,
		PS_HUNT0 = 4'd1,
		PS_HUNT1 = 4'd2,
		PS_HUNT2 = 4'd3,
		PS_HUNT3 = 4'd4,
		PS_SIZE  = 4'd5,
		PS_SEQ   = 4'd6,
		PS_DATA  = 4'd7,
		PS_CKSUM = 4'd8
	} ps_t;

	ps_t                   state_q, state_d;
	logic [IDX_W-1:0]      idx_q;
	logic [SIZE_ACC_W-1:0] size_q, size_d;
	logic [SEQ_ACC_W-1:0]  seq_q, seq_d;
	logic [31:0]           sum_q, sum_d;
	logic [CKSUM_W-1:0]    ck_q, ck_d;
	logic                  in_sync_q, in_sync_d;
	logic                  ever_q, ever_d;
	logic                  accept;
	logic [CFG_W-1:0]      idx_inc;
	logic [CFG_W-1:0]      eff_size;
	logic [CFG_W-1:0]      data_len;
	logic [31:0]           lane;
	ev_t                   ev;
	logic                  pvalid;
	logic [IDX_W-1:0]      pidx;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	assign idx_inc = CFG_W'(idx_q) + CFG_W'(1);
	assign lane    = 32'(rx_byte) << {idx_q[1:0], 3'b000};

	always_comb begin
		if (expected_frame_size > CFG_W'(MAX_FRAME_BYTES)) begin
			eff_size = CFG_W'(MAX_FRAME_BYTES);
		end else begin
			eff_size = expected_frame_size;
		end
		if (eff_size < CFG_W'(SEQ_BYTES + CHECKSUM_BYTES + 1)) begin
			data_len = CFG_W'(1);
		end else begin
			data_len = eff_size - CFG_W'(SEQ_BYTES + CHECKSUM_BYTES);
		end
	end

	always_comb begin
		state_d   = state_q;
		size_d    = size_q;
		seq_d     = seq_q;
		sum_d     = sum_q;
		ck_d      = ck_q;
		in_sync_d = in_sync_q;
		ever_d    = ever_q;
		ev        = EV_NONE;
		pvalid    = 1'b0;
		pidx      = '0;
		case (state_q)
			PS_LOST, PS_HUNT0: begin
				if (state_q == PS_LOST) begin
					in_sync_d = 1'b0;
					if (ever_q) begin
						ev = EV_LOST;
					end
				end
				if (rx_byte == SYNC_A) begin
					state_d = PS_HUNT1;
				end else if (in_sync_d) begin
					state_d = PS_LOST;
				end else begin
					state_d = PS_HUNT0;
				end
			end
			PS_HUNT1: begin
				state_d = (rx_byte == SYNC_B) ? PS_HUNT2 : PS_LOST;
			end
			PS_HUNT2: begin
				state_d = (rx_byte == SYNC_A) ? PS_HUNT3 : PS_LOST;
			end
			PS_HUNT3: begin
				if (rx_byte == SYNC_B) begin
					state_d   = PS_SIZE;
					ever_d    = 1'b1;
					in_sync_d = 1'b1;
					ev        = EV_SYNC;
				end else begin
					state_d = PS_LOST;
				end
			end
			PS_SIZE: begin
				size_d = ((idx_q == '0) ? '0 : size_q) + SIZE_ACC_W'(lane);
				if (idx_inc >= CFG_W'(SIZE_FIELD_BYTES)) begin
					if (32'(size_d) != 32'(expected_frame_size)) begin
						state_d   = PS_HUNT0;
						in_sync_d = 1'b0;
						ev        = EV_SIZE;
					end else begin
						state_d = PS_SEQ;
					end
				end
			end
			PS_SEQ: begin
				seq_d  = ((idx_q == '0) ? '0 : seq_q) + SEQ_ACC_W'(lane);
				sum_d  = ((idx_q == '0) ? '0 : sum_q) + 32'(rx_byte);
				pvalid = 1'b1;
				pidx   = idx_q;
				if (idx_inc >= CFG_W'(SEQ_BYTES)) begin
					state_d = PS_DATA;
				end
			end
			PS_DATA: begin
				sum_d  = sum_q + 32'(rx_byte);
				pvalid = 1'b1;
				pidx   = idx_q + IDX_W'(SEQ_BYTES);
				if (idx_inc >= data_len) begin
					state_d = PS_CKSUM;
				end
			end
			PS_CKSUM: begin
				ck_d = ((idx_q == '0) ? '0 : ck_q) + CKSUM_W'(lane);
				if (idx_inc >= CFG_W'(CHECKSUM_BYTES)) begin
					ev      = (ck_d == sum_q[CKSUM_W-1:0]) ? EV_GOOD : EV_CKSUM;
					state_d = PS_HUNT0;
				end
			end
			default: begin
				state_d = PS_LOST;
			end
		endcase
	end

	always_comb begin
		q_item.is_clear      = (op == OP_CLEAR);
		q_item.payload_valid = 1'b0;
		q_item.payload_index = '0;
		q_item.payload_byte  = '0;
		q_item.ev            = EV_NONE;
		q_item.seq_number    = SEQ_OUT_W'(seq_q);
		if (op == OP_BYTE) begin
			q_item.payload_valid = pvalid;
			q_item.payload_index = pidx;
			q_item.payload_byte  = pvalid ? rx_byte : 8'd0;
			q_item.ev            = ev;
			q_item.seq_number    = SEQ_OUT_W'(seq_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= PS_LOST;
			idx_q     <= '0;
			size_q    <= '0;
			seq_q     <= '0;
			sum_q     <= '0;
			ck_q      <= '0;
			in_sync_q <= 1'b0;
			ever_q    <= 1'b0;
		end else if (accept && op == OP_BYTE) begin
			state_q   <= state_d;
			idx_q     <= (state_d != state_q) ? '0 : idx_q + IDX_W'(1);
			size_q    <= size_d;
			seq_q     <= seq_d;
			sum_q     <= sum_d;
			ck_q      <= ck_d;
			in_sync_q <= in_sync_d;
			ever_q    <= ever_d;
		end
	end

endmodule

@@ hw/rtl/swfd_queue.sv @@
module swfd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  swfd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output swfd_pkg::item_t pop_item,
	output logic            empty
);
	import swfd_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t         mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/swfd_back.sv @@
module swfd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  swfd_pkg::item_t                q_item,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           payload_valid,
	output logic [swfd_pkg::IDX_W-1:0]     payload_index,
	output logic [7:0]                     payload_byte,
	output logic [2:0]                     event_res,
	output logic [swfd_pkg::SEQ_OUT_W-1:0] seq_number,
	output logic [swfd_pkg::CNT_W-1:0]     byte_count,
	output logic [swfd_pkg::CNT_W-1:0]     good_frame_count,
	output logic [swfd_pkg::CNT_W-1:0]     sync_count,
	output logic [swfd_pkg::CNT_W-1:0]     lost_sync_count,
	output logic [swfd_pkg::CNT_W-1:0]     size_error_count,
	output logic [swfd_pkg::CNT_W-1:0]     checksum_error_count
);
	import swfd_pkg::*;

	logic                 out_valid_q;
	logic                 pvalid_q;
	logic [IDX_W-1:0]     pidx_q;
	logic [7:0]           pbyte_q;
	ev_t                  ev_q;
	logic [SEQ_OUT_W-1:0] seq_q;
	logic [CNT_W-1:0]     bytes_q, good_q, sync_q, lost_q, size_q, cksum_q;

	// Counters double as the output register: they only move on a pop.
	assign q_pop = !q_empty && (!out_valid_q || !out_stall);

	assign out_valid            = out_valid_q;
	assign payload_valid        = pvalid_q;
	assign payload_index        = pidx_q;
	assign payload_byte         = pbyte_q;
	assign event_res            = ev_q;
	assign seq_number           = seq_q;
	assign byte_count           = bytes_q;
	assign good_frame_count     = good_q;
	assign sync_count           = sync_q;
	assign lost_sync_count      = lost_q;
	assign size_error_count     = size_q;
	assign checksum_error_count = cksum_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pvalid_q <= q_item.payload_valid;
			pidx_q   <= q_item.payload_index;
			pbyte_q  <= q_item.payload_byte;
			ev_q     <= q_item.ev;
			seq_q    <= q_item.seq_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			bytes_q     <= '0;
			good_q      <= '0;
			sync_q      <= '0;
			lost_q      <= '0;
			size_q      <= '0;
			cksum_q     <= '0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (q_item.is_clear) begin
					bytes_q <= '0;
					good_q  <= '0;
					sync_q  <= '0;
					lost_q  <= '0;
					size_q  <= '0;
					cksum_q <= '0;
				end else begin
					bytes_q <= bytes_q + CNT_W'(1);
					case (q_item.ev)
						EV_SYNC:  sync_q  <= sync_q + CNT_W'(1);
						EV_LOST:  lost_q  <= lost_q + CNT_W'(1);
						EV_SIZE:  size_q  <= size_q + CNT_W'(1);
						EV_CKSUM: cksum_q <= cksum_q + CNT_W'(1);
						EV_GOOD:  good_q  <= good_q + CNT_W'(1);
						default: begin
						end
					endcase
				end
			end
		end
	end

endmodule
